// File: sv/five_tuple_flow_table_defines.svh
// Assertion macros for the five-tuple flow table checker.
// Used by sv/ftft_checker.sv; depends on nothing else.
`ifndef FIVE_TUPLE_FLOW_TABLE_DEFINES_SVH
`define FIVE_TUPLE_FLOW_TABLE_DEFINES_SVH

// Property checked out of reset.
`define FTFT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property that also covers the reset cycle.
`define FTFT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/ftft_pkg.sv
// Shared types, constants and the key hash for the five-tuple flow table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ftft_pkg;

   localparam int BUCKET_BITS = 10;
   localparam int WAYS        = 4;
   localparam int NBUCKETS    = 1 << BUCKET_BITS;
   localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CNT_W       = $clog2(NBUCKETS * WAYS + 1);

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_EVICT  = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   localparam logic [31:0] HASH_MULT = 32'h045d9f3b;
   localparam logic [15:0] TTL_RESET = 16'd120;
   localparam logic        TTL_ADDR  = 1'b0;

   typedef struct packed {
      logic [7:0]  proto;
      logic [15:0] dport;
      logic [15:0] sport;
      logic [31:0] dst;
      logic [31:0] src;
   } key_type;

   typedef struct packed {
      logic [WAYS-1:0]             valid;
      key_type [WAYS-1:0]          key;
      logic [WAYS-1:0][31:0]       seen;
   } row_type;

   // Result item, lowest field in the lowest bits.
   typedef struct packed {
      logic [31:0] eviction_total;
      logic [31:0] miss_total;
      logic [31:0] hit_total;
      logic [12:0] live_count;
      logic [12:0] evicted_now;
      logic [31:0] entry_time;
      logic [1:0]  way;
      logic [9:0]  bucket;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic ld_req;
      logic ld_prod;
      logic rd_bucket;
      logic exec;
      logic clr_wr;
      logic ev_rd;
      logic ev_wb;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic       last_row;
      logic       out_free;
      logic [1:0] op;
   } stat_type;

   function automatic logic [31:0] hash_fold(key_type k);
      logic [31:0] x;
      x = k.src ^ k.dst ^ {k.sport, k.dport} ^ {24'd0, k.proto};
      return x ^ (x >> 16);
   endfunction

endpackage
`default_nettype wire

// File: sv/ftft_ctrl.sv
// Controller state machine of the five-tuple flow table.
// Depends on ftft_pkg; drives the datapath through cmd_type.
`timescale 1ns / 1ps
`default_nettype none
module ftft_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire ftft_pkg::stat_type stat,
   output ftft_pkg::cmd_type       cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EXEC  = 3'd4;
   localparam logic [2:0] S_EV_RD = 3'd5;
   localparam logic [2:0] S_EV_WB = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.last_row) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.ld_req = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            // op is captured by now; branch on it
            case (stat.op)
               ftft_pkg::CMD_EVICT: state_in = S_EV_RD;
               ftft_pkg::CMD_NOP:   state_in = S_DONE;
               default: begin
                  cmd.ld_prod = 1'b1;
                  state_in    = S_READ;
               end
            endcase
         end
         S_READ: begin
            cmd.rd_bucket = 1'b1;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EV_RD: begin
            cmd.ev_rd = 1'b1;
            state_in  = S_EV_WB;
         end
         S_EV_WB: begin
            cmd.ev_wb = 1'b1;
            state_in  = stat.last_row ? S_DONE : S_EV_RD;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

// File: sv/ftft_datapath.sv
// Datapath of the five-tuple flow table: hash, bucket store, counters, result register.
// Depends on ftft_pkg; controlled by ftft_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module ftft_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ftft_pkg::cmd_type cmd,
   output ftft_pkg::stat_type     stat,
   input  wire logic [1:0]        req_tuser,
   input  wire logic [135:0]      req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [167:0]           rsp_tdata,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata
);

   localparam int BB = ftft_pkg::BUCKET_BITS;
   localparam int CW = ftft_pkg::CNT_W;

   ftft_pkg::row_type mem [ftft_pkg::NBUCKETS];

   logic [1:0]              op_ff, op_in;
   ftft_pkg::key_type       key_ff, key_in;
   logic [31:0]             now_ff, now_in;
   logic [31:0]             prod_ff, prod_in;
   logic [BB-1:0]           bucket_ff, bucket_in;
   logic [BB-1:0]           row_ff, row_in;
   logic [CW-1:0]           acc_ff, acc_in;
   logic [CW-1:0]           live_ff, live_in;
   logic [31:0]             hits_ff, hits_in;
   logic [31:0]             miss_ff, miss_in;
   logic [31:0]             evt_ff, evt_in;
   logic [15:0]             ttl_ff, ttl_in;
   ftft_pkg::row_type       rd_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   ftft_pkg::rsp_type       rsp_ff, rsp_in;

   logic [63:0]             prod_full;
   logic [31:0]             h_fin;
   logic [ftft_pkg::WAYS-1:0] match, stale;
   logic                    hit, free;
   logic [ftft_pkg::WAY_W-1:0] hit_way, free_way;
   logic [CW-1:0]           stale_cnt;
   logic [32:0]             evt_sum;
   logic [32:0]             age_limit [ftft_pkg::WAYS];
   logic                    mem_rd, mem_wr;
   logic [BB-1:0]           rd_addr, wr_addr;
   ftft_pkg::row_type       wr_row;
   logic                    csr_wr;

   assign prod_full = 64'(ftft_pkg::hash_fold(key_ff)) * 64'(ftft_pkg::HASH_MULT);
   assign h_fin     = prod_ff ^ (prod_ff >> 16);

   always_comb begin
      hit = 1'b0;  hit_way = '0;
      free = 1'b0; free_way = '0;
      stale_cnt = '0;
      for (int w = ftft_pkg::WAYS - 1; w >= 0; w--) begin
         match[w] = rd_ff.valid[w] && (rd_ff.key[w] == key_ff);
         age_limit[w] = {1'b0, rd_ff.seen[w]} + {17'd0, ttl_ff};
         stale[w] = rd_ff.valid[w] && (age_limit[w] < {1'b0, now_ff});
         // descending scan leaves the lowest way selected
         if (match[w]) begin
            hit = 1'b1; hit_way = ftft_pkg::WAY_W'(w);
         end
         if (!rd_ff.valid[w]) begin
            free = 1'b1; free_way = ftft_pkg::WAY_W'(w);
         end
         stale_cnt = stale_cnt + CW'(stale[w]);
      end
   end

   assign evt_sum = {1'b0, evt_ff} + 33'(stale_cnt);
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == ftft_pkg::TTL_ADDR);
   assign csr_prdata = {16'd0, ttl_ff};

   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      prod_in      = prod_ff;
      bucket_in    = bucket_ff;
      row_in       = row_ff;
      acc_in       = acc_ff;
      live_in      = live_ff;
      hits_in      = hits_ff;
      miss_in      = miss_ff;
      evt_in       = evt_ff;
      ttl_in       = csr_wr ? csr_pwdata[15:0] : ttl_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_rd       = 1'b0;
      mem_wr       = 1'b0;
      rd_addr      = row_ff;
      wr_addr      = row_ff;
      wr_row       = rd_ff;

      if (cmd.ld_req) begin
         op_in  = req_tuser;
         key_in = req_tdata[103:0];
         now_in = req_tdata[135:104];
         row_in = '0;
         acc_in = '0;
      end
      if (cmd.ld_prod) prod_in = prod_full[31:0];
      if (cmd.rd_bucket) begin
         bucket_in = h_fin[BB-1:0];
         mem_rd    = 1'b1;
         rd_addr   = h_fin[BB-1:0];
      end
      if (cmd.clr_wr) begin
         mem_wr = 1'b1;
         wr_row = '0;
         row_in = row_ff + 1'b1;
      end
      if (cmd.ev_rd) mem_rd = 1'b1;
      if (cmd.ev_wb) begin
         mem_wr = 1'b1;
         wr_row.valid = rd_ff.valid & ~stale;
         row_in  = row_ff + 1'b1;
         acc_in  = acc_ff + stale_cnt;
         live_in = live_ff - stale_cnt;
         evt_in  = evt_sum[32] ? '1 : evt_sum[31:0];
      end
      if (cmd.exec || cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_in = '0;
         rsp_in.status = ftft_pkg::STAT_OK;
      end
      if (cmd.exec) begin
         rsp_in.bucket = 10'(bucket_ff);
         if (op_ff == ftft_pkg::CMD_LOOKUP) begin
            if (hit) begin
               rsp_in.way        = 2'(hit_way);
               rsp_in.entry_time = rd_ff.seen[hit_way];
               hits_in = (hits_ff == '1) ? hits_ff : hits_ff + 1'b1;
            end else begin
               rsp_in.status = ftft_pkg::STAT_MISS;
               miss_in = (miss_ff == '1) ? miss_ff : miss_ff + 1'b1;
            end
         end else if (free) begin
            mem_wr  = 1'b1;
            wr_addr = bucket_ff;
            wr_row.valid[free_way] = 1'b1;
            wr_row.key[free_way]   = key_ff;
            wr_row.seen[free_way]  = now_ff;
            live_in = live_ff + 1'b1;
            rsp_in.way        = 2'(free_way);
            rsp_in.entry_time = now_ff;
         end else begin
            rsp_in.status = ftft_pkg::STAT_FULL;
         end
      end
      if (cmd.finish && op_ff == ftft_pkg::CMD_EVICT) rsp_in.evicted_now = 13'(acc_ff);
      if (cmd.exec || cmd.finish) begin
         rsp_in.live_count     = 13'(live_in);
         rsp_in.hit_total      = hits_in;
         rsp_in.miss_total     = miss_in;
         rsp_in.eviction_total = evt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) mem[wr_addr] <= wr_row;
      if (mem_rd) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      now_ff    <= now_in;
      prod_ff   <= prod_in;
      bucket_ff <= bucket_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         row_ff       <= '0;
         live_ff      <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         evt_ff       <= '0;
         ttl_ff       <= ftft_pkg::TTL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         live_ff      <= live_in;
         hits_ff      <= hits_in;
         miss_ff      <= miss_in;
         evt_ff       <= evt_in;
         ttl_ff       <= ttl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.last_row = (row_ff == BB'(ftft_pkg::NBUCKETS - 1));
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign stat.op       = op_ff;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_ff;

endmodule
`default_nettype wire

// File: sv/five_tuple_flow_table.sv
// Lookup and insert go from accept through hash multiply, bucket read, and compare and
// write-back to the registered result; an unused command goes straight to its result.
// Evict sweeps every bucket row, read then write-back, before its result is registered.
// Throughput: one item at a time; the next item is accepted once the result is registered.
// Reset: synchronous; a clearing pass over all 2^BUCKET_BITS rows (1024) empties the store,
// with req_tready low. Configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module five_tuple_flow_table (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [135:0] req_tdata,  // src_addr, dst_addr, sport, dport, protocol, now
   input  wire logic [1:0]   req_tuser,  // command
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status, bucket, way, entry_time, evicted_now, live_count, hit_total, miss_total,
   // eviction_total
   output logic [167:0]      rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   ftft_pkg::cmd_type  cmd;
   ftft_pkg::stat_type stat;

   assign csr_pready = 1'b1;

   ftft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ftft_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule
`default_nettype wire

// File: sv/ftft_checker.sv
// Port-level checks on the five-tuple flow table, bound to the top level.
// Depends on five_tuple_flow_table_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "five_tuple_flow_table_defines.svh"
module ftft_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [167:0] rsp_tdata,
   input wire logic         csr_pready
);

   `FTFT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")
   `FTFT_ASSERT_RST(a_clear_pass, reset |=> !req_tready, "input taken during clearing pass")
   `FTFT_ASSERT(a_live_bound, rsp_tvalid |-> rsp_tdata[71:59] <= 13'd4096, "live count too high")
   `FTFT_ASSERT(a_status_code, rsp_tvalid |-> rsp_tdata[1:0] != 2'd3, "bad status code")
   `FTFT_ASSERT_RST(a_pready, csr_pready, "csr_pready low")

endmodule

bind five_tuple_flow_table ftft_checker u_chk (.*);
`default_nettype wire

// File: test/five_tuple_flow_table_checker.sv
// Checker for the five-tuple flow table: watches the request, result and register ports,
// predicts every result from its own copy of the table and compares field by field.
// Depends on ftft_pkg for the key and result layouts and the command and status codes.
`timescale 1ns / 1ps
module five_tuple_flow_table_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [135:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [167:0] rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   input  wire logic         csr_pready,
   output int                mismatches,
   output int                outstanding
);

   localparam int ENTRIES = ftft_pkg::NBUCKETS * ftft_pkg::WAYS;

   bit                 slot_used [ENTRIES];
   ftft_pkg::key_type  slot_key  [ENTRIES];
   logic [31:0]        slot_seen [ENTRIES];
   logic [12:0]        live_entries;
   logic [31:0]        lookup_hits, lookup_misses, evict_sum;
   logic [15:0]        age_limit;
   ftft_pkg::rsp_type  pending_rsp [$];
   int                 fail_cnt;

   function automatic logic [9:0] flow_bucket(ftft_pkg::key_type k);
      logic [31:0] h;
      h = k.src ^ k.dst ^ {k.sport, k.dport} ^ {24'd0, k.proto};
      h = h ^ (h >> 16);
      h = h * 32'h045d9f3b;
      h = h ^ (h >> 16);
      return h[9:0];
   endfunction

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == 32'hffffffff) ? v : v + 32'd1;
   endfunction

   // Apply one command to the table copy and return the result it should produce.
   function automatic ftft_pkg::rsp_type table_update(logic [1:0] cmd, ftft_pkg::key_type k,
                                                      logic [31:0] t);
      ftft_pkg::rsp_type r;
      logic [9:0] b;
      bit done;
      int idx;
      r = '0;
      done = 0;
      b = flow_bucket(k);
      case (cmd)
         ftft_pkg::CMD_LOOKUP: begin
            r.bucket = b;
            for (int w = 0; w < ftft_pkg::WAYS && !done; w++) begin
               idx = b * ftft_pkg::WAYS + w;
               if (slot_used[idx] && slot_key[idx] == k) begin
                  done = 1;
                  r.way = 2'(w);
                  r.entry_time = slot_seen[idx];
               end
            end
            if (done) begin
               lookup_hits = bump(lookup_hits);
            end else begin
               r.status = ftft_pkg::STAT_MISS;
               lookup_misses = bump(lookup_misses);
            end
         end
         ftft_pkg::CMD_INSERT: begin
            r.bucket = b;
            for (int w = 0; w < ftft_pkg::WAYS && !done; w++) begin
               idx = b * ftft_pkg::WAYS + w;
               if (!slot_used[idx]) begin
                  done = 1;
                  slot_used[idx] = 1;
                  slot_key[idx] = k;
                  slot_seen[idx] = t;
                  live_entries++;
                  r.way = 2'(w);
                  r.entry_time = t;
               end
            end
            if (!done) r.status = ftft_pkg::STAT_FULL;
         end
         ftft_pkg::CMD_EVICT: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_used[i] && ({1'b0, slot_seen[i]} + age_limit < {1'b0, t})) begin
                  slot_used[i] = 0;
                  live_entries--;
                  r.evicted_now++;
                  evict_sum = bump(evict_sum);
               end
            end
         end
         default: ;
      endcase
      r.live_count = live_entries;
      r.hit_total = lookup_hits;
      r.miss_total = lookup_misses;
      r.eviction_total = evict_sum;
      return r;
   endfunction

   function automatic void match(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_cnt++;
      end
   endfunction

   always @(posedge clock) begin
      ftft_pkg::rsp_type want, got;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) slot_used[i] = 0;
         live_entries = '0;
         lookup_hits = '0;
         lookup_misses = '0;
         evict_sum = '0;
         age_limit = ftft_pkg::TTL_RESET;
         pending_rsp.delete();
         fail_cnt = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = ftft_pkg::rsp_type'(rsp_tdata);
            if (pending_rsp.size() == 0) begin
               $error("result item with nothing expected: %0h", rsp_tdata);
               fail_cnt++;
            end else begin
               want = pending_rsp.pop_front();
               match("status", want.status, got.status);
               match("bucket", want.bucket, got.bucket);
               match("way", want.way, got.way);
               match("entry_time", want.entry_time, got.entry_time);
               match("evicted_now", want.evicted_now, got.evicted_now);
               match("live_count", want.live_count, got.live_count);
               match("hit_total", want.hit_total, got.hit_total);
               match("miss_total", want.miss_total, got.miss_total);
               match("eviction_total", want.eviction_total, got.eviction_total);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == {2'b00, ftft_pkg::TTL_ADDR})
            age_limit = csr_pwdata[15:0];
         if (req_tvalid && req_tready)
            pending_rsp.push_back(table_update(req_tuser,
                                               ftft_pkg::key_type'(req_tdata[103:0]),
                                               req_tdata[135:104]));
      end
      mismatches <= fail_cnt;
      outstanding <= pending_rsp.size();
   end

endmodule

// File: test/five_tuple_flow_table_tb.sv
// Top of the five-tuple flow table testbench: clock, reset, register writes and stimulus
// with random gaps and stalls, and the final verdict.
// Depends on ftft_pkg, five_tuple_flow_table and five_tuple_flow_table_checker.
`timescale 1ns / 1ps
module five_tuple_flow_table_tb;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;  // src_addr, dst_addr, sport, dport, protocol, now
   logic [1:0]   req_tuser = '0;  // command
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   // status, bucket, way, entry_time, evicted_now, live_count, hit_total, miss_total,
   // eviction_total
   logic [167:0] rsp_tdata;
   logic         csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           mismatches, outstanding, cycles;
   bit           no_gaps;
   logic [31:0]  clock_sec;
   ftft_pkg::key_type flow_pool [24];

   five_tuple_flow_table u_dut (.*);

   five_tuple_flow_table_checker u_chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_psel, .csr_penable, .csr_pwrite,
      .csr_paddr, .csr_pwdata, .csr_pready, .mismatches, .outstanding
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: before each item, stall at random unless the no-gap mode is on.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
         n = no_gaps ? 0 : $urandom_range(0, 10);
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic ftft_pkg::key_type any_flow();
      ftft_pkg::key_type k;
      k.src = $urandom;
      k.dst = $urandom;
      k.sport = 16'($urandom);
      k.dport = 16'($urandom);
      k.proto = 8'($urandom);
      return k;
   endfunction

   task automatic send(logic [1:0] cmd, ftft_pkg::key_type k, logic [31:0] t);
      int n;
      n = no_gaps ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {t, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_ttl(logic [15:0] v);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {2'b00, ftft_pkg::TTL_ADDR};
      csr_pwdata <= {16'd0, v};
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // Drain: lower valid and wait until every expected result has come back.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_phase(int count);
      logic [1:0] cmd;
      int pick;
      ftft_pkg::key_type k;
      logic [31:0] t;
      for (int i = 0; i < 24; i++) flow_pool[i] = any_flow();
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         cmd = (pick < 45) ? ftft_pkg::CMD_LOOKUP : (pick < 85) ? ftft_pkg::CMD_INSERT :
               (pick < 95) ? ftft_pkg::CMD_EVICT : ftft_pkg::CMD_NOP;
         k = ($urandom_range(0, 3) == 0) ? any_flow() : flow_pool[$urandom_range(0, 23)];
         clock_sec += $urandom_range(0, 30);
         t = clock_sec;
         if ($urandom_range(0, 19) == 0) t = $urandom;
         if (cmd == ftft_pkg::CMD_EVICT && $urandom_range(0, 9) == 0) t = 32'hffffffff;
         send(cmd, k, t);
      end
      drain();
   endtask

   initial begin
      ftft_pkg::key_type zero_key, ones_key;
      zero_key = '0;
      ones_key = '1;
      cycles = 0;
      no_gaps = 0;
      clock_sec = 0;
      repeat (2) @(negedge clock);
      reset <= 0;

      // Directed: field extremes, duplicates, a full bucket, the unused command.
      send(ftft_pkg::CMD_LOOKUP, zero_key, 32'd0);
      send(ftft_pkg::CMD_INSERT, zero_key, 32'd0);
      send(ftft_pkg::CMD_INSERT, ones_key, 32'hffffffff);
      send(ftft_pkg::CMD_LOOKUP, zero_key, 32'd7);
      send(ftft_pkg::CMD_LOOKUP, ones_key, 32'd7);
      repeat (4) send(ftft_pkg::CMD_INSERT, ones_key, 32'd50);
      send(ftft_pkg::CMD_LOOKUP, ones_key, 32'd0);
      send(ftft_pkg::CMD_NOP, ones_key, 32'hffffffff);
      send(ftft_pkg::CMD_EVICT, zero_key, 32'd120);
      send(ftft_pkg::CMD_EVICT, zero_key, 32'd121);
      send(ftft_pkg::CMD_LOOKUP, zero_key, 32'd0);
      drain();

      // Zero age limit: only entries strictly older than now go.
      write_ttl(16'd0);
      send(ftft_pkg::CMD_EVICT, zero_key, 32'hffffffff);
      send(ftft_pkg::CMD_INSERT, zero_key, 32'd5);
      send(ftft_pkg::CMD_EVICT, ones_key, 32'd5);
      send(ftft_pkg::CMD_EVICT, ones_key, 32'd6);
      send(ftft_pkg::CMD_LOOKUP, zero_key, 32'd6);
      drain();

      write_ttl(16'd1);
      random_phase(330);
      write_ttl(16'hffff);
      random_phase(330);
      write_ttl(16'($urandom_range(1, 65535)));
      random_phase(330);
      write_ttl(16'd120);
      random_phase(330);
      write_ttl(16'd0);
      random_phase(310);

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/ftft_pkg.sv
sv/ftft_ctrl.sv
sv/ftft_datapath.sv
sv/five_tuple_flow_table.sv
sv/ftft_checker.sv
test/five_tuple_flow_table_checker.sv
test/five_tuple_flow_table_tb.sv
